// File: src/ultrasonic_wave_gesture_detector_top_assert.svh
// assertion macros for the wave gesture detector checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ULTRASONIC_WAVE_GESTURE_DETECTOR_TOP_ASSERT_SVH
`define ULTRASONIC_WAVE_GESTURE_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication
`define UWGD_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("uwgd assertion failed");

// next-cycle implication
`define UWGD_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("uwgd assertion failed");

`endif

// File: src/uwgd_pkg.sv
// types, register codes and constants of the wave gesture detector
// no dependencies
`timescale 1ns / 1ps

package uwgd_pkg;

  // configuration port
  localparam int CfgWidth    = 16;
  localparam int CfgIdxWidth = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegNearLimit   = 3'd0,
    RegMediumMin   = 3'd1,
    RegMediumMax   = 3'd2,
    RegDebounce    = 3'd3,
    RegDoubleWin   = 3'd4,
    RegCooldown    = 3'd5,
    RegDispTimeout = 3'd6
  } cfg_reg_e;

  // register reset values
  localparam logic [9:0]  NearLimitRst   = 10'd5;
  localparam logic [9:0]  MediumMinRst   = 10'd10;
  localparam logic [9:0]  MediumMaxRst   = 10'd20;
  localparam logic [15:0] DebounceRst    = 16'd150;
  localparam logic [15:0] DoubleWinRst   = 16'd600;
  localparam logic [15:0] CooldownRst    = 16'd2000;
  localparam logic [15:0] DispTimeoutRst = 16'd5000;

  // distance = echo * 10 / 582, division by reciprocal multiply (exact for 19 bit x)
  localparam logic [14:0] EchoMaxUs = 15'd30000;
  localparam int          DistDen   = 582;
  localparam int          DistShift = 29;
  localparam logic [19:0] DistMul   = 20'((2 ** DistShift + DistDen - 1) / DistDen);
  localparam logic signed [10:0] NoEchoDist = -11'sd1;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [14:0] echo_us;
  } in_item_t;

  typedef struct packed {
    logic signed [10:0] distance_cm;
    logic [1:0]         wave_total;
    logic               sound_toggled;
    logic               sound_on;
    logic               refresh_request;
    logic               display_on;
    logic               display_switched_off;
  } out_item_t;

endpackage

// File: src/ultrasonic_wave_gesture_detector_top.sv
// An accepted item is held in the input register, its result then in the result register.
// Throughput: one item per cycle unless the result stalls; one pass through
// the distance multiplier and the state update stands between the two registers.
// Reset: asynchronous, active low; clears both stages' valid flags and the gesture
// state (sound starts on), loads the default register values. No clearing pass.
// uses uwgd_pkg
`timescale 1ns / 1ps

module ultrasonic_wave_gesture_detector_top
  import uwgd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  // measurement items
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_item_t               in_item_i,
  // result items
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_item_t              out_item_o
);

  // configuration registers
  logic [9:0]  near_limit_q, medium_min_q, medium_max_q;
  logic [15:0] debounce_q, double_win_q, cooldown_q, disp_timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_limit_q   <= NearLimitRst;
      medium_min_q   <= MediumMinRst;
      medium_max_q   <= MediumMaxRst;
      debounce_q     <= DebounceRst;
      double_win_q   <= DoubleWinRst;
      cooldown_q     <= CooldownRst;
      disp_timeout_q <= DispTimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegNearLimit:   near_limit_q   <= cfg_data_i[9:0];
        RegMediumMin:   medium_min_q   <= cfg_data_i[9:0];
        RegMediumMax:   medium_max_q   <= cfg_data_i[9:0];
        RegDebounce:    debounce_q     <= cfg_data_i;
        RegDoubleWin:   double_win_q   <= cfg_data_i;
        RegCooldown:    cooldown_q     <= cfg_data_i;
        RegDispTimeout: disp_timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake
  logic     s1_valid_q;
  in_item_t s1_item_q;
  logic     out_valid_q;
  out_item_t out_item_q;
  logic     advance, in_accept;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item_i;
    end
  end

  // distance from echo width
  logic [14:0] echo_c;
  logic [18:0] echo_x10;
  logic [38:0] dist_prod;
  logic [9:0]  dist_cm;
  logic        has_echo, very_close, mid_band;

  assign has_echo  = s1_item_q.echo_us != '0;
  assign echo_c    = (s1_item_q.echo_us > EchoMaxUs) ? EchoMaxUs : s1_item_q.echo_us;
  assign echo_x10  = {1'b0, echo_c, 3'b000} + {3'b000, echo_c, 1'b0};
  assign dist_prod = 39'(echo_x10) * 39'(DistMul);
  assign dist_cm   = dist_prod[DistShift +: 10];

  assign very_close = has_echo && (dist_cm != '0) && (dist_cm <= near_limit_q);
  assign mid_band   = has_echo && (dist_cm >= medium_min_q) && (dist_cm <= medium_max_q);

  // gesture state
  logic        was_near_q, was_near_d;
  logic [31:0] last_wave_q, last_wave_d;
  logic [1:0]  wave_cnt_q, wave_cnt_d;
  logic [31:0] last_gest_q, last_gest_d;
  logic        sound_q, sound_d;
  logic        disp_q, disp_d;
  logic [31:0] disp_start_q, disp_start_d;

  logic [31:0] now;
  logic [1:0]  cnt1;
  logic [31:0] lw1;
  logic        toggled, refresh, switched_off;

  assign now = s1_item_q.now_ms;

  always_comb begin
    cnt1         = wave_cnt_q;
    lw1          = last_wave_q;
    wave_cnt_d   = wave_cnt_q;
    last_wave_d  = last_wave_q;
    last_gest_d  = last_gest_q;
    sound_d      = sound_q;
    disp_d       = disp_q;
    disp_start_d = disp_start_q;
    toggled      = 1'b0;
    refresh      = 1'b0;
    switched_off = 1'b0;
    was_near_d   = very_close;

    // debounced rising edge into the near range
    if (very_close && !was_near_q && ((now - last_wave_q) > 32'(debounce_q))) begin
      cnt1 = (wave_cnt_q < 2'd2) ? wave_cnt_q + 2'd1 : wave_cnt_q;
      lw1  = now;
    end
    wave_cnt_d  = cnt1;
    last_wave_d = lw1;

    // double wave toggles sound, else a lone wave expires
    if (cnt1 == 2'd2 && ((now - lw1) < 32'(double_win_q))) begin
      sound_d      = !sound_q;
      toggled      = 1'b1;
      disp_d       = 1'b1;
      disp_start_d = now;
      wave_cnt_d   = 2'd0;
      last_wave_d  = now;
    end else if (cnt1 == 2'd1 && ((now - lw1) > 32'(double_win_q))) begin
      wave_cnt_d = 2'd0;
    end

    // medium range gesture outside cooldown
    if (mid_band && ((now - last_gest_q) > 32'(cooldown_q))) begin
      refresh      = 1'b1;
      disp_d       = 1'b1;
      disp_start_d = now;
      last_gest_d  = now;
    end

    // display timeout
    if (disp_d && ((now - disp_start_d) > 32'(disp_timeout_q))) begin
      disp_d       = 1'b0;
      switched_off = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_near_q   <= 1'b0;
      last_wave_q  <= '0;
      wave_cnt_q   <= '0;
      last_gest_q  <= '0;
      sound_q      <= 1'b1;
      disp_q       <= 1'b0;
      disp_start_q <= '0;
    end else if (advance) begin
      was_near_q   <= was_near_d;
      last_wave_q  <= last_wave_d;
      wave_cnt_q   <= wave_cnt_d;
      last_gest_q  <= last_gest_d;
      sound_q      <= sound_d;
      disp_q       <= disp_d;
      disp_start_q <= disp_start_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q.distance_cm          <= has_echo ? $signed({1'b0, dist_cm}) : NoEchoDist;
      out_item_q.wave_total           <= wave_cnt_d;
      out_item_q.sound_toggled        <= toggled;
      out_item_q.sound_on             <= sound_d;
      out_item_q.refresh_request      <= refresh;
      out_item_q.display_on           <= disp_d;
      out_item_q.display_switched_off <= switched_off;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: src/uwgd_checker.sv
// port level checks of the wave gesture detector, bound to the top level
// uses uwgd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "ultrasonic_wave_gesture_detector_top_assert.svh"

module uwgd_checker
  import uwgd_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input out_item_t              out_item_o
);

  // a stalled result stays offered
  `UWGD_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // the input stalls only behind a stalled result
  `UWGD_ASSERT_IMP(a_in_stall_cause, in_stall_o, out_valid_o && out_stall_i)

  // a toggle or refresh leaves the display on in the same item
  `UWGD_ASSERT_IMP(a_event_disp_on,
    out_valid_o && (out_item_o.sound_toggled || out_item_o.refresh_request),
    out_item_o.display_on && !out_item_o.display_switched_off)

  // a double wave consumes the count
  `UWGD_ASSERT_IMP(a_toggle_clears_count,
    out_valid_o && out_item_o.sound_toggled, out_item_o.wave_total == 2'd0)

  // the only negative distance is the no-echo marker
  `UWGD_ASSERT_IMP(a_dist_sign,
    out_valid_o && out_item_o.distance_cm[10], out_item_o.distance_cm == NoEchoDist)

endmodule

bind ultrasonic_wave_gesture_detector_top uwgd_checker u_uwgd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
